[rtl/core/vnac_pkg.sv]
// Shared types, constants and helpers for the vertex normal accumulator.
// Used by every module under rtl/core except vnac_ram; depends on nothing.
package vnac_pkg;

	// Table and field sizes (vertex depth is a power of two)
	localparam int VERTEX_DEPTH = 1024;
	localparam int POS_W        = 24;
	localparam int NRM_W        = 16;
	localparam int FRAC_W       = NRM_W - 2;
	localparam int CNT_W        = 16;
	localparam int IDX_FIELD_W  = 10;
	localparam int IDX_W        = $clog2(VERTEX_DEPTH);
	localparam int OPC_W        = 2;

	// Edge and product widths
	localparam int EDGE_SHIFT = (POS_W > 30) ? POS_W - 30 : 0;
	localparam int EDGE_W     = POS_W + 1 - EDGE_SHIFT;
	localparam int MUL_W      = (EDGE_W > CNT_W + 1) ? EDGE_W : CNT_W + 1;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int VEC_W      = PROD_W + 1;

	// Normalizer widths
	localparam int RED_W = 30;
	localparam int SQ_W  = 64;
	localparam int LEN_W = RED_W + 1;
	localparam int REM_W = LEN_W + 1;
	localparam int NUM_W = RED_W + FRAC_W + 1;
	localparam int Q_W   = FRAC_W + 1;
	localparam int STEP_W = $clog2(Q_W);

	// Memory words
	localparam int POS_WORD_W = 3 * POS_W;
	localparam int NRM_WORD_W = 3 * NRM_W + CNT_W;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Stream widths
	localparam int IN_FIELDS_W = 3 * IDX_FIELD_W + 3 * POS_W;
	localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = ((NRM_WORD_W + 7) / 8) * 8;
	localparam int POS_OFS     = 3 * IDX_FIELD_W;

	typedef enum logic [OPC_W-1:0] {
		OP_WRITE = 2'd0,
		OP_TRI   = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} opcode_t;

	typedef logic signed [VEC_W-1:0]  vec_t;
	typedef logic signed [NRM_W-1:0]  nrm_t;
	typedef logic signed [EDGE_W-1:0] edge_t;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_WR, S_RD_ADDR, S_RD_DATA,
		S_TA, S_TB, S_TC, S_TD, S_EDGE, S_CROSS,
		S_FACE_GO, S_FACE_WAIT, S_CRD, S_CDAT,
		S_BLEND, S_BN_GO, S_BN_WAIT, S_CWR
	} ctrl_state_t;

	typedef enum logic [2:0] {
		N_IDLE, N_SHIFT, N_SQ, N_ROOT, N_DIVI, N_DIV, N_DONE
	} norm_state_t;

	// Controller to datapath
	typedef struct packed {
		logic       cap_in;
		logic       clr_we;
		logic       pos_we;
		logic       pos_re;
		logic [1:0] idx_sel;
		logic       pos_cap;
		logic [1:0] pos_slot;
		logic       edge_cap;
		logic       mac_en;
		logic       mac_blend;
		logic [2:0] step;
		logic       norm_start;
		logic       face_cap;
		logic       nrm_re;
		logic       old_cap;
		logic       nrm_we;
		logic       out_load;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;
		logic norm_done;
		logic first_hit;
		logic out_free;
	} dp_status_t;

	// Edge component truncated toward zero by EDGE_SHIFT bits
	function automatic edge_t edge_trunc(input logic signed [POS_W:0] d);
		logic [POS_W:0]    m;
		logic [EDGE_W-1:0] t;
		begin
			m = d[POS_W] ? (POS_W+1)'(-d) : (POS_W+1)'(d);
			t = EDGE_W'(m >> EDGE_SHIFT);
			return d[POS_W] ? edge_t'(-t) : edge_t'(t);
		end
	endfunction

endpackage

[rtl/core/vnac_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module vnac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

[rtl/core/vnac_norm.sv]
// Iterative vector normalizer: range reduce, sum of squares, bitwise
// square root and restoring division per component. Depends on vnac_pkg.
module vnac_norm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  vnac_pkg::vec_t vec [3],
	output logic           done,
	output vnac_pkg::nrm_t nrm [3]
);
	import vnac_pkg::*;

	norm_state_t        state_q, state_next;
	logic [2:0]         neg_q;
	logic [VEC_W-1:0]   mag_q [3];
	logic [1:0]         sq_idx_q;
	logic [SQ_W-1:0]    sum_q, rad_q, root_q, bit_q;
	logic [1:0]         cidx_q;
	logic [REM_W-1:0]   rem_q;
	logic [FRAC_W:0]    lo_q;
	logic [Q_W-1:0]     quo_q;
	logic [STEP_W-1:0]  st_q;
	nrm_t               nrm_q [3];

	logic               big, zero, take, ge;
	logic [RED_W-1:0]   sq_op;
	logic [2*RED_W-1:0] sq_p;
	logic [SQ_W-1:0]    sum_next, trial;
	logic [LEN_W-1:0]   len;
	logic [NUM_W-1:0]   num;
	logic [REM_W-1:0]   rem2;
	logic [Q_W-1:0]     qn;

	// Per-step arithmetic
	always_comb begin
		big  = 1'b0;
		zero = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (mag_q[i][VEC_W-1:RED_W] != '0) big = 1'b1;
			if (mag_q[i] != '0) zero = 1'b0;
		end
		sq_op    = mag_q[sq_idx_q][RED_W-1:0];
		sq_p     = sq_op * sq_op;
		sum_next = sum_q + SQ_W'(sq_p);
		trial    = root_q + bit_q;
		take     = rad_q >= trial;
		len      = (root_q[LEN_W-1:0] == '0) ? LEN_W'(1) : root_q[LEN_W-1:0];
		num      = (NUM_W'(mag_q[cidx_q][RED_W-1:0]) << FRAC_W) + NUM_W'(len >> 1);
		rem2     = {rem_q[REM_W-2:0], lo_q[FRAC_W]};
		ge       = rem2 >= REM_W'(len);
		qn       = {quo_q[Q_W-2:0], ge};
	end

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			N_IDLE:  if (start) state_next = N_SHIFT;
			N_SHIFT: begin
				if (zero) state_next = N_DONE;
				else if (!big) state_next = N_SQ;
			end
			N_SQ:    if (sq_idx_q == 2'd2) state_next = N_ROOT;
			N_ROOT:  if (bit_q[0]) state_next = N_DIVI;
			N_DIVI:  state_next = N_DIV;
			N_DIV:   if (st_q == '0) state_next = (cidx_q == 2'd2) ? N_DONE : N_DIVI;
			N_DONE:  state_next = N_IDLE;
			default: state_next = N_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		done = (state_q == N_DONE);
		nrm  = nrm_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= vec[i][VEC_W-1];
						mag_q[i] <= vec[i][VEC_W-1] ? VEC_W'(-vec[i]) : VEC_W'(vec[i]);
					end
					sum_q    <= '0;
					sq_idx_q <= '0;
				end
			end
			N_SHIFT: begin
				if (zero) begin
					for (int i = 0; i < 3; i++) nrm_q[i] <= '0;
				end else if (big) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
				end
			end
			N_SQ: begin
				sum_q    <= sum_next;
				sq_idx_q <= sq_idx_q + 2'd1;
				rad_q    <= sum_next;
				root_q   <= '0;
				bit_q    <= SQ_W'(1) << (SQ_W - 2);
				cidx_q   <= '0;
			end
			N_ROOT: begin
				if (take) begin
					rad_q  <= rad_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_DIVI: begin
				rem_q <= REM_W'(num[NUM_W-1:FRAC_W+1]);
				lo_q  <= num[FRAC_W:0];
				quo_q <= '0;
				st_q  <= STEP_W'(Q_W - 1);
			end
			N_DIV: begin
				rem_q <= ge ? rem2 - REM_W'(len) : rem2;
				lo_q  <= lo_q << 1;
				quo_q <= qn;
				st_q  <= st_q - STEP_W'(1);
				if (st_q == '0) begin
					nrm_q[cidx_q] <= neg_q[cidx_q] ? nrm_t'(-NRM_W'(qn)) : nrm_t'(NRM_W'(qn));
					cidx_q        <= cidx_q + 2'd1;
				end
			end
			default: ;
		endcase
	end
endmodule

[rtl/core/vnac_dp.sv]
// Datapath: position and normal stores, edge and cross product MAC,
// blend, normalizer and output register. Depends on vnac_pkg, vnac_ram, vnac_norm.
module vnac_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [vnac_pkg::IN_DATA_W-1:0] s_tdata,
	input  vnac_pkg::dp_cmd_t              cmd,
	output vnac_pkg::dp_status_t           status,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [vnac_pkg::OUT_DATA_W-1:0] m_tdata
);
	import vnac_pkg::*;

	logic [IDX_W-1:0]      idx_q [3];
	logic [POS_WORD_W-1:0] pos_in_q;
	logic [POS_WORD_W-1:0] p_q [3];
	edge_t                 e1_q [3], e2_q [3];
	logic signed [PROD_W-1:0] acc_q;
	vec_t                  vec_q [3];
	nrm_t                  face_q [3], old_q [3];
	logic [CNT_W-1:0]      k_q;
	logic [IDX_W-1:0]      clr_addr_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [IDX_W-1:0]      sel_idx;
	logic [POS_WORD_W-1:0] pos_rd;
	logic [NRM_WORD_W-1:0] nrm_rd, nrm_wd;
	logic [CNT_W-1:0]      rd_cnt;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [CNT_W:0] weight;
	logic [1:0]            bi;
	logic                  norm_done;
	nrm_t                  norm_out [3];
	nrm_t                  wr_n [3];

	// Address select
	always_comb begin
		case (cmd.idx_sel)
			2'd1:    sel_idx = idx_q[1];
			2'd2:    sel_idx = idx_q[2];
			default: sel_idx = idx_q[0];
		endcase
	end

	// Input capture
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			for (int i = 0; i < 3; i++) begin
				idx_q[i] <= IDX_W'(s_tdata[i*IDX_FIELD_W +: IDX_FIELD_W] % VERTEX_DEPTH);
			end
			pos_in_q <= s_tdata[POS_OFS +: POS_WORD_W];
		end
	end

	vnac_ram #(.WIDTH(POS_WORD_W), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
		.clk     (clk),
		.we      (cmd.pos_we),
		.wr_addr (idx_q[0]),
		.wr_data (pos_in_q),
		.re      (cmd.pos_re),
		.rd_addr (sel_idx),
		.rd_data (pos_rd)
	);

	// Corner positions, then edges from corner a
	always_ff @(posedge clk) begin
		if (cmd.pos_cap) begin
			p_q[cmd.pos_slot] <= pos_rd;
		end
		if (cmd.edge_cap) begin
			for (int i = 0; i < 3; i++) begin
				e1_q[i] <= edge_trunc((POS_W+1)'($signed(p_q[1][i*POS_W +: POS_W]))
					- (POS_W+1)'($signed(p_q[0][i*POS_W +: POS_W])));
				e2_q[i] <= edge_trunc((POS_W+1)'($signed(p_q[2][i*POS_W +: POS_W]))
					- (POS_W+1)'($signed(p_q[0][i*POS_W +: POS_W])));
			end
		end
	end

	// Shared multiplier: cross product terms or blend weights
	assign bi     = cmd.step[1:0];
	assign weight = $signed({1'b0, k_q - CNT_W'(1)});
	always_comb begin
		if (cmd.mac_blend) begin
			mul_a = MUL_W'(old_q[bi]);
			mul_b = MUL_W'(weight);
		end else begin
			case (cmd.step)
				3'd0:    begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[2]); end
				3'd1:    begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[1]); end
				3'd2:    begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[0]); end
				3'd3:    begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[2]); end
				3'd4:    begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[1]); end
				default: begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[0]); end
			endcase
		end
		mul_p = mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_en) begin
			if (cmd.mac_blend) begin
				vec_q[bi] <= VEC_W'(mul_p) + VEC_W'(face_q[bi]);
			end else if (!cmd.step[0]) begin
				acc_q <= mul_p;
			end else begin
				vec_q[cmd.step[2:1]] <= VEC_W'(acc_q) - VEC_W'(mul_p);
			end
		end
	end

	vnac_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.norm_start),
		.vec    (vec_q),
		.done   (norm_done),
		.nrm    (norm_out)
	);

	// Face normal and old corner state
	assign rd_cnt = nrm_rd[3*NRM_W +: CNT_W];
	always_ff @(posedge clk) begin
		if (cmd.face_cap) begin
			face_q <= norm_out;
		end
		if (cmd.old_cap) begin
			for (int i = 0; i < 3; i++) old_q[i] <= nrm_t'(nrm_rd[i*NRM_W +: NRM_W]);
			k_q <= (rd_cnt == CNT_MAX) ? CNT_MAX : rd_cnt + CNT_W'(1);
		end
	end

	// Normal store write data: face on first hit, blend otherwise
	always_comb begin
		for (int i = 0; i < 3; i++) wr_n[i] = (k_q == CNT_W'(1)) ? face_q[i] : norm_out[i];
		nrm_wd = cmd.clr_we ? '0 : {k_q, wr_n[2], wr_n[1], wr_n[0]};
	end

	vnac_ram #(.WIDTH(NRM_WORD_W), .DEPTH(VERTEX_DEPTH)) u_nrm_ram (
		.clk     (clk),
		.we      (cmd.clr_we | cmd.nrm_we),
		.wr_addr (cmd.clr_we ? clr_addr_q : sel_idx),
		.wr_data (nrm_wd),
		.re      (cmd.nrm_re),
		.rd_addr (sel_idx),
		.rd_data (nrm_rd)
	);

	// Clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_we) begin
			clr_addr_q <= status.clr_last ? '0 : clr_addr_q + IDX_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= (rd_cnt == '0) ? '0 : OUT_DATA_W'(nrm_rd);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		status.clr_last  = (clr_addr_q == IDX_W'(VERTEX_DEPTH - 1));
		status.norm_done = norm_done;
		status.first_hit = (rd_cnt == '0);
		status.out_free  = !m_tvalid_q || m_tready;
	end
endmodule

[rtl/core/vnac_ctrl.sv]
// Controller state machine: sequences clear sweeps, writes, reads and
// the triangle corner updates. Depends on vnac_pkg.
module vnac_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  vnac_pkg::opcode_t    opcode,
	output logic                 s_tready,
	input  vnac_pkg::dp_status_t status,
	output vnac_pkg::dp_cmd_t    cmd
);
	import vnac_pkg::*;

	ctrl_state_t state_q, state_next;
	logic [2:0]  step_q;
	logic [1:0]  corner_q;

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_CLR:       if (status.clr_last) state_next = S_IDLE;
			S_IDLE: begin
				if (s_tvalid) begin
					unique case (opcode)
						OP_WRITE: state_next = S_WR;
						OP_TRI:   state_next = S_TA;
						OP_READ:  state_next = S_RD_ADDR;
						OP_CLEAR: state_next = S_CLR;
						default:  state_next = S_IDLE;
					endcase
				end
			end
			S_WR:        state_next = S_IDLE;
			S_RD_ADDR:   state_next = S_RD_DATA;
			S_RD_DATA:   if (status.out_free) state_next = S_IDLE;
			S_TA:        state_next = S_TB;
			S_TB:        state_next = S_TC;
			S_TC:        state_next = S_TD;
			S_TD:        state_next = S_EDGE;
			S_EDGE:      state_next = S_CROSS;
			S_CROSS:     if (step_q == 3'd5) state_next = S_FACE_GO;
			S_FACE_GO:   state_next = S_FACE_WAIT;
			S_FACE_WAIT: if (status.norm_done) state_next = S_CRD;
			S_CRD:       state_next = S_CDAT;
			S_CDAT:      state_next = status.first_hit ? S_CWR : S_BLEND;
			S_BLEND:     if (step_q == 3'd2) state_next = S_BN_GO;
			S_BN_GO:     state_next = S_BN_WAIT;
			S_BN_WAIT:   if (status.norm_done) state_next = S_CWR;
			S_CWR:       state_next = (corner_q == 2'd2) ? S_IDLE : S_CRD;
			default:     state_next = S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		s_tready = (state_q == S_IDLE);
		cmd.step = step_q;
		unique case (state_q)
			S_CLR:       cmd.clr_we = 1'b1;
			S_IDLE:      cmd.cap_in = s_tvalid;
			S_WR:        cmd.pos_we = 1'b1;
			S_RD_ADDR:   cmd.nrm_re = 1'b1;
			S_RD_DATA:   cmd.out_load = status.out_free;
			S_TA:        cmd.pos_re = 1'b1;
			S_TB: begin
				cmd.pos_re  = 1'b1;
				cmd.idx_sel = 2'd1;
				cmd.pos_cap = 1'b1;
			end
			S_TC: begin
				cmd.pos_re   = 1'b1;
				cmd.idx_sel  = 2'd2;
				cmd.pos_cap  = 1'b1;
				cmd.pos_slot = 2'd1;
			end
			S_TD: begin
				cmd.pos_cap  = 1'b1;
				cmd.pos_slot = 2'd2;
			end
			S_EDGE:      cmd.edge_cap = 1'b1;
			S_CROSS:     cmd.mac_en = 1'b1;
			S_FACE_GO:   cmd.norm_start = 1'b1;
			S_FACE_WAIT: cmd.face_cap = status.norm_done;
			S_CRD: begin
				cmd.nrm_re  = 1'b1;
				cmd.idx_sel = corner_q;
			end
			S_CDAT:      cmd.old_cap = 1'b1;
			S_BLEND: begin
				cmd.mac_en    = 1'b1;
				cmd.mac_blend = 1'b1;
			end
			S_BN_GO:     cmd.norm_start = 1'b1;
			S_BN_WAIT:   ;
			S_CWR: begin
				cmd.nrm_we  = 1'b1;
				cmd.idx_sel = corner_q;
			end
			default:     ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			step_q   <= '0;
			corner_q <= '0;
		end else begin
			state_q <= state_next;
			// MAC step counter
			if (state_q == S_CROSS || state_q == S_BLEND) begin
				step_q <= step_q + 3'd1;
			end else begin
				step_q <= '0;
			end
			// Corner counter
			if (state_q == S_FACE_WAIT) begin
				corner_q <= '0;
			end else if (state_q == S_CWR) begin
				corner_q <= corner_q + 2'd1;
			end
		end
	end
endmodule

[rtl/core/vertex_normal_accumulator_core.sv]
// Top level of the vertex normal accumulator: controller plus datapath.
// Depends on vnac_pkg, vnac_ctrl, vnac_dp.
//
//  channel  dir  handshake          tdata / tuser
//  s_       in   s_tvalid/s_tready  tdata: index_a,b,c, pos_x,y,z; tuser: opcode
//  m_       out  m_tvalid/m_tready  tdata: normal_x,y,z, seen_count
//
// Write stores a position, read waits for a free output register, clear sweeps the store.
// Add triangle: position reads and cross product, then one normalization (a
// 32-step square root and three 15-step divisions), then per corner a normal read
// and write plus, after the first hit, a blend and one more normalization.
// After reset the normal store is swept; no item is taken then.
// A waiting result does not stall write, triangle or clear items.
module vertex_normal_accumulator_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// index_a[9:0], index_b[19:10], index_c[29:20], pos_x, pos_y, pos_z, pad
	input  logic [vnac_pkg::IN_DATA_W-1:0]  s_tdata,
	// opcode[1:0]
	input  logic [vnac_pkg::OPC_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// normal_x[15:0], normal_y[31:16], normal_z[47:32], seen_count[63:48]
	output logic [vnac_pkg::OUT_DATA_W-1:0] m_tdata
);
	import vnac_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	vnac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.opcode   (opcode_t'(s_tuser)),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	vnac_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// A result is only loaded into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free)
		else $error("result loaded over a pending result");

	// No item is taken during a clearing sweep
	a_clr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_we |-> !s_tready)
		else $error("item accepted during clearing sweep");

	// The normalizer never finishes in the cycle after it starts
	a_norm_lat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.norm_start |=> !status.norm_done)
		else $error("normalizer done too early");

	// Sweep writes and corner writes never coincide
	a_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.nrm_we |-> !cmd.clr_we)
		else $error("normal store write conflict");
endmodule
